// ----- rtl/sli_pkg.sv -----
package sli_pkg;

  // operation codes carried in the request
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_DUMP   = 2'd3;

  // result status codes
  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_DELETED   = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_CLEARED   = 3'd4;
  localparam logic [2:0] STATUS_ENTRY     = 3'd5;
  localparam logic [2:0] STATUS_EMPTY     = 3'd6;

  // request payload
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } sli_req_t;

  // result payload
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [4:0]         entry_count;
    logic               last;
  } sli_rsp_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  // control broadcast to the cell row
  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] operand;
  } cell_ctrl_t;

endpackage

// ----- rtl/sli_cell.sv -----
module sli_cell (
  input  logic                       clk_i,
  input  sli_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       occ_i,
  input  logic                       tail_i,
  input  logic signed [31:0]         left_value_i,
  input  logic                       left_lt_i,
  input  logic signed [31:0]         right_value_i,
  input  logic signed [31:0]         head_value_i,
  output logic signed [31:0]         value_o,
  output logic                       lt_o,
  output logic                       eq_o
);
  import sli_pkg::*;

  logic signed [31:0] value_q, value_d;
  logic               lt;

  // local compare against the broadcast operand
  assign lt    = occ_i && (value_q < ctrl_i.operand);
  assign lt_o  = lt;
  assign eq_o  = occ_i && (value_q == ctrl_i.operand);
  assign value_o = value_q;

  // next value: keep, take the operand, or take a neighbour's value
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (!lt) begin
          value_d = left_lt_i ? ctrl_i.operand : left_value_i;
        end
      end
      CELL_DEL: begin
        if (occ_i && !lt) begin
          value_d = right_value_i;
        end
      end
      CELL_ROT: begin
        value_d = tail_i ? head_value_i : right_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- rtl/sorted_list_insert_delete_core.sv -----
// Sorted bounded multiset of signed 32-bit values, held in a row of
// CAPACITY cells, each cell one entry, kept in ascending order.
// Request channel (in_valid_i/in_ready_o, in_req_i): mode and value.
//   insert places the value before the first entry not smaller, or answers
//   full; delete removes one equal entry or answers not found; clear empties
//   the table; dump lists every entry in order.
// Result channel (out_valid_o/out_ready_i, out_rsp_o): status, entry value,
//   entry count after the operation, and last on the final result.
// Timing: insert, clear and an empty dump give their result from the execute
//   state once the request is taken; delete first registers the compare across
//   the row, then shifts and answers from the delete state; a dump gives one
//   entry per cycle while the receiver does not stall, last on the final entry.
// The row is updated by one broadcast compare and one neighbour shift per
//   insert or delete, and a dump rotates the row once per listed entry.
// Reset clears the entry count; entry storage is not cleared and is read
//   only after it is written.
// A stalled receiver holds the result register; the row waits in place
//   until the register frees, and a new request is taken once the current
//   one has handed its final result to the register.
module sorted_list_insert_delete_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sli_pkg::sli_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sli_pkg::sli_rsp_t out_rsp_o
);
  import sli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEL,
    ST_DUMP
  } state_e;

  state_e             state_q;
  logic [1:0]         mode_q;
  logic signed [31:0] operand_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      dump_cnt_q;
  logic               found_q;
  logic               out_valid_q;
  sli_rsp_t           out_rsp_q;

  logic               out_free;
  logic               full;
  logic               dump_last;
  logic               rsp_load;
  cell_ctrl_t         ctrl;

  logic signed [31:0] value_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign out_free  = !out_valid_q || out_ready_i;
  assign full      = (count_q == CW'(CAPACITY));
  assign dump_last = (CW'(dump_cnt_q + CW'(1)) == count_q);

  // row operation for this cycle
  always_comb begin
    ctrl.operand = operand_q;
    ctrl.op      = CELL_HOLD;
    case (state_q)
      ST_EXEC: begin
        if (mode_q == MODE_INSERT && out_free && !full) begin
          ctrl.op = CELL_INS;
        end
      end
      ST_DEL: begin
        if (out_free && found_q) begin
          ctrl.op = CELL_DEL;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.op = CELL_ROT;
        end
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
  end

  // result register loads this cycle
  always_comb begin
    rsp_load = 1'b0;
    case (state_q)
      ST_EXEC: begin
        rsp_load = out_free && (mode_q != MODE_DELETE) &&
                   (mode_q != MODE_DUMP || count_q == '0);
      end
      ST_DEL: begin
        rsp_load = out_free;
      end
      ST_DUMP: begin
        rsp_load = out_free;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  // cell row, each cell wired to its neighbours
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] left_value;
    logic               left_lt;
    logic signed [31:0] right_value;

    if (k == 0) begin : g_first
      assign left_value = operand_q;
      assign left_lt    = 1'b1;
    end else begin : g_inner_l
      assign left_value = value_w[k-1];
      assign left_lt    = lt_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_value = value_w[0];
    end else begin : g_inner_r
      assign right_value = value_w[k+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (CW'(k) < count_q),
      .tail_i       (CW'(k + 1) == count_q),
      .left_value_i (left_value),
      .left_lt_i    (left_lt),
      .right_value_i(right_value),
      .head_value_i (value_w[0]),
      .value_o      (value_w[k]),
      .lt_o         (lt_w[k]),
      .eq_o         (eq_w[k])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_INSERT;
      operand_q   <= '0;
      count_q     <= '0;
      dump_cnt_q  <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q    <= in_req_i.mode;
            operand_q <= in_req_i.value;
            state_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (mode_q)
            MODE_INSERT: begin
              if (out_free) begin
                state_q     <= ST_IDLE;
                if (full) begin
                  out_rsp_q <= '{STATUS_FULL, 32'sd0, 5'(count_q), 1'b1};
                end else begin
                  count_q   <= CW'(count_q + CW'(1));
                  out_rsp_q <= '{STATUS_INSERTED, 32'sd0,
                                 5'(CW'(count_q + CW'(1))), 1'b1};
                end
              end
            end
            MODE_DELETE: begin
              found_q <= |eq_w;
              state_q <= ST_DEL;
            end
            MODE_CLEAR: begin
              if (out_free) begin
                count_q     <= '0;
                out_rsp_q   <= '{STATUS_CLEARED, 32'sd0, 5'd0, 1'b1};
                state_q     <= ST_IDLE;
              end
            end
            default: begin
              if (count_q == '0) begin
                if (out_free) begin
                  out_rsp_q   <= '{STATUS_EMPTY, 32'sd0, 5'd0, 1'b1};
                  state_q     <= ST_IDLE;
                end
              end else begin
                dump_cnt_q <= '0;
                state_q    <= ST_DUMP;
              end
            end
          endcase
        end
        ST_DEL: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            if (found_q) begin
              count_q   <= CW'(count_q - CW'(1));
              out_rsp_q <= '{STATUS_DELETED, 32'sd0,
                             5'(CW'(count_q - CW'(1))), 1'b1};
            end else begin
              out_rsp_q <= '{STATUS_NOT_FOUND, 32'sd0, 5'(count_q), 1'b1};
            end
          end
        end
        ST_DUMP: begin
          if (out_free) begin
            out_rsp_q   <= '{STATUS_ENTRY, value_w[0], 5'(count_q), dump_last};
            dump_cnt_q  <= CW'(dump_cnt_q + CW'(1));
            if (dump_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sli_checker.sv -----
module sli_core_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input sli_pkg::sli_rsp_t out_rsp_i
);
  import sli_pkg::*;

  // a stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rsp_i))
    else $error("stalled result changed");

  // only entry results carry a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.status != STATUS_ENTRY |-> out_rsp_i.entry_value == 32'sd0)
    else $error("non-entry result with a value");

  // every non-entry result closes its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.status != STATUS_ENTRY |-> out_rsp_i.last)
    else $error("non-entry result without last");

  // count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> CAPACITY > 31 || out_rsp_i.entry_count <= 5'(CAPACITY))
    else $error("entry count beyond capacity");

  // a taken request keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

endmodule

bind sorted_list_insert_delete_core sli_core_checker #(.CAPACITY(CAPACITY)) u_sli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_i  (out_rsp_o)
);

// ----- test/sli_checker.sv -----
module sli_checker
  import sli_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  sli_req_t in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  sli_rsp_t out_rsp_i,
  output int       fail_count_o,
  output int       awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the sorted table
  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_fill;

  // results still owed by the block, oldest first
  sli_rsp_t           awaited_rsp_q [$];

  function automatic sli_rsp_t make_rsp(input logic [2:0] st, input logic signed [31:0] val,
                                        input int fill, input logic lst);
    sli_rsp_t r;
    r.status      = st;
    r.entry_value = val;
    r.entry_count = 5'(fill);
    r.last        = lst;
    return r;
  endfunction

  // apply one request to the shadow table and queue what it should produce
  task automatic apply_list_op(input sli_req_t req);
    logic signed [31:0] operand;
    int                 pos;
    int                 k;
    operand = req.value;
    pos     = 0;
    case (req.mode)
      MODE_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          awaited_rsp_q.push_back(make_rsp(STATUS_FULL, '0, shadow_fill, 1'b1));
        end else begin
          // before the first entry not smaller, so a new value goes ahead of equal ones
          while (pos < shadow_fill && shadow_list[pos] < operand) pos++;
          for (k = shadow_fill; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = operand;
          shadow_fill++;
          awaited_rsp_q.push_back(make_rsp(STATUS_INSERTED, '0, shadow_fill, 1'b1));
        end
      end
      MODE_DELETE: begin
        while (pos < shadow_fill && shadow_list[pos] != operand) pos++;
        if (pos >= shadow_fill) begin
          awaited_rsp_q.push_back(make_rsp(STATUS_NOT_FOUND, '0, shadow_fill, 1'b1));
        end else begin
          for (k = pos; k + 1 < shadow_fill; k++) shadow_list[k] = shadow_list[k+1];
          shadow_fill--;
          awaited_rsp_q.push_back(make_rsp(STATUS_DELETED, '0, shadow_fill, 1'b1));
        end
      end
      MODE_CLEAR: begin
        shadow_fill = 0;
        awaited_rsp_q.push_back(make_rsp(STATUS_CLEARED, '0, 0, 1'b1));
      end
      default: begin
        // dump: one result per entry, or a single empty marker
        if (shadow_fill == 0) begin
          awaited_rsp_q.push_back(make_rsp(STATUS_EMPTY, '0, 0, 1'b1));
        end else begin
          for (k = 0; k < shadow_fill; k++) begin
            awaited_rsp_q.push_back(make_rsp(STATUS_ENTRY, shadow_list[k], shadow_fill,
                                             (k == shadow_fill - 1)));
          end
        end
      end
    endcase
  endtask

  initial begin
    fail_count_o = 0;
    awaited_o    = 0;
  end

  // watch both channels, compare results against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    sli_rsp_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      awaited_rsp_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: status %0d value %0d count %0d last %0b",
                     out_rsp_i.status, out_rsp_i.entry_value, out_rsp_i.entry_count,
                     out_rsp_i.last);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (out_rsp_i.status !== want.status ||
              out_rsp_i.entry_value !== want.entry_value ||
              out_rsp_i.entry_count !== want.entry_count ||
              out_rsp_i.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: status %0d/%0d value %0d/%0d count %0d/%0d last %0b/%0b",
                       want.status, out_rsp_i.status, want.entry_value,
                       out_rsp_i.entry_value, want.entry_count, out_rsp_i.entry_count,
                       want.last, out_rsp_i.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_list_op(in_req_i);
    end
    awaited_o = awaited_rsp_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import sli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 16;
  localparam int NUM_RANDOM = 330;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  sli_req_t in_req    = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  sli_rsp_t out_rsp;

  int       fail_count;
  int       awaited;
  int       send_idle_pct = 23;
  int       recv_idle_pct = 56;
  bit       hold_off_req  = 1'b0;
  int       issued        = 0;

  // values recently inserted, so that deletes find matches
  logic signed [31:0] recent_vals [8] = '{default: '0};
  int                 recent_wr = 0;

  sorted_list_insert_delete_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  sli_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .awaited_o   (awaited)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on demand
  initial begin : drain
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = 80;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one request, entered and left at a falling edge
  task automatic issue(input logic [1:0] mode, input logic signed [31:0] value);
    sli_req_t req;
    req.mode  = mode;
    req.value = value;
    // idling phases: receiver-heavy, then swapped to sender-heavy, then none
    if (issued < 115) begin
      send_idle_pct = 23;
      recv_idle_pct = 56;
    end else if (issued < 230) begin
      send_idle_pct = 56;
      recv_idle_pct = 23;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (issued == 60 || issued == 280) hold_off_req = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    if (mode == MODE_INSERT) begin
      recent_vals[recent_wr] = value;
      recent_wr = (recent_wr + 1) % 8;
    end
    issued++;
  endtask

  function automatic logic signed [31:0] pick_value(input bit for_delete);
    int r;
    r = $urandom_range(99);
    if (for_delete && r < 45) return recent_vals[$urandom_range(7)];
    if (r < 70) return 32'(int'($urandom_range(16)) - 8);
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  initial begin : stimulus
    int r;
    bit fill_up;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, duplicates, misses, clear and reuse
    issue(MODE_DUMP, $urandom());
    issue(MODE_DELETE, 32'sd5);
    issue(MODE_INSERT, 32'sh7fff_ffff);
    issue(MODE_INSERT, 32'sh8000_0000);
    issue(MODE_INSERT, 32'sd0);
    issue(MODE_INSERT, -32'sd1);
    issue(MODE_INSERT, 32'sd0);
    issue(MODE_INSERT, 32'sd1);
    issue(MODE_DUMP, $urandom());
    issue(MODE_DELETE, 32'sd7);
    issue(MODE_DELETE, 32'sd0);
    issue(MODE_DELETE, 32'sh7fff_ffff);
    issue(MODE_DELETE, 32'sh8000_0000);
    issue(MODE_DUMP, $urandom());
    issue(MODE_CLEAR, $urandom());
    issue(MODE_DUMP, $urandom());
    issue(MODE_INSERT, 32'sd3);
    issue(MODE_DUMP, $urandom());

    // random: alternate fill-heavy and drain-heavy stretches so full is reached
    for (int i = 0; i < NUM_RANDOM; i++) begin
      fill_up = ((i / 50) % 2 == 0);
      r = $urandom_range(99);
      if (fill_up) begin
        if (r < 68)      issue(MODE_INSERT, pick_value(1'b0));
        else if (r < 84) issue(MODE_DELETE, pick_value(1'b1));
        else if (r < 98) issue(MODE_DUMP, $urandom());
        else             issue(MODE_CLEAR, $urandom());
      end else begin
        if (r < 35)      issue(MODE_INSERT, pick_value(1'b0));
        else if (r < 72) issue(MODE_DELETE, pick_value(1'b1));
        else if (r < 93) issue(MODE_DUMP, $urandom());
        else             issue(MODE_CLEAR, $urandom());
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then a short tail
    while (awaited != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && awaited == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
